// ===== rtl/ptb_pkg.sv =====
// shared types and constants for the periodic / one-shot timer bank
// no dependencies; imported by ptb_front, ptb_back and the top level
package ptb_pkg;

    localparam int NUM_TIMERS_DEF = 8;
    localparam int IDX_W          = 3;
    localparam int VAL_W          = 32;
    localparam int MASK_W         = 8;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic [2:0] {
        CMD_TICK    = 3'd0,
        CMD_CREATE  = 3'd1,
        CMD_START   = 3'd2,
        CMD_STOP    = 3'd3,
        CMD_RESET   = 3'd4,
        CMD_RESTART = 3'd5,
        CMD_SET     = 3'd6,
        CMD_QUERY   = 3'd7
    } t_cmd;

    // coarse class picked by the front end
    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_CREATE = 2'd1,
        KIND_SLOT   = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        t_cmd              cmd;
        logic [IDX_W-1:0]  idx;
        logic [VAL_W-1:0]  value;
        logic              one_shot;
    } t_item;

endpackage

// ===== rtl/ptb_front.sv =====
// front end of the timer bank: accepts command words, classifies them
// and holds them in a short queue for the back end; depends on ptb_pkg
module ptb_front
    import ptb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_command,
    input  logic [IDX_W-1:0]   i_timer_index,
    input  logic [VAL_W-1:0]   i_value,
    input  logic               i_one_shot,
    output logic               o_q_valid,
    output t_item              o_q_item,
    input  logic               i_q_pop
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    t_item              r_queue [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count,  n_count;
    t_item              w_item;
    logic               w_push;
    logic               w_pop;
    t_cmd               w_cmd;

    // classify the incoming word
    always_comb begin
        w_cmd = t_cmd'(i_command);
        case (w_cmd)
            CMD_TICK:   w_item.kind = KIND_TICK;
            CMD_CREATE: w_item.kind = KIND_CREATE;
            default:    w_item.kind = KIND_SLOT;
        endcase
        w_item.cmd      = w_cmd;
        w_item.idx      = i_timer_index;
        w_item.value    = i_value;
        w_item.one_shot = i_one_shot;
    end

    assign o_ready   = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_q_valid = (r_count != '0);
    assign o_q_item  = r_queue[r_rd_ptr];
    assign w_push    = i_valid && o_ready;
    assign w_pop     = i_q_pop && o_q_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(r_wr_ptr + 1'b1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(r_rd_ptr + 1'b1);
        end
        case ({w_push, w_pop})
            2'b10:   n_count = CNT_W'(r_count + 1'b1);
            2'b01:   n_count = CNT_W'(r_count - 1'b1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= w_item;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue fill count out of range");

endmodule

// ===== rtl/ptb_back.sv =====
// back end of the timer bank: executes queued commands against the timer
// memories, sweeps all created timers on a tick, holds the result word; uses ptb_pkg
module ptb_back
    import ptb_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  t_item              i_q_item,
    output logic               o_q_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [MASK_W-1:0]  o_fired_mask,
    output logic [IDX_W-1:0]   o_slot,
    output logic               o_running,
    output logic [VAL_W-1:0]   o_target_out,
    output logic               o_error
);

    localparam int CW = $clog2(NUM_TIMERS + 1);
    localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int XW = (AW > 3) ? AW : 3;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_EXEC  = 2'd1,
        S_SWEEP = 2'd2,
        S_DONE  = 2'd3
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_created, n_created;
    logic [AW-1:0]       r_ptr, n_ptr;
    t_item               r_item, n_item;
    logic [NUM_TIMERS-1:0] r_running, n_running;
    logic [NUM_TIMERS-1:0] r_oneshot, n_oneshot;

    logic [MASK_W-1:0]   r_res_fired, n_res_fired;
    logic [IDX_W-1:0]    r_res_slot, n_res_slot;
    logic                r_res_run, n_res_run;
    logic [VAL_W-1:0]    r_res_tgt, n_res_tgt;
    logic                r_res_err, n_res_err;

    logic                r_out_valid, n_out_valid;
    logic [MASK_W-1:0]   r_out_fired, n_out_fired;
    logic [IDX_W-1:0]    r_out_slot, n_out_slot;
    logic                r_out_run, n_out_run;
    logic [VAL_W-1:0]    r_out_tgt, n_out_tgt;
    logic                r_out_err, n_out_err;

    // counter and target memories
    logic [VAL_W-1:0]    r_cnt_mem [NUM_TIMERS];
    logic [VAL_W-1:0]    r_tgt_mem [NUM_TIMERS];
    logic [VAL_W-1:0]    r_cnt_rd;
    logic [VAL_W-1:0]    r_tgt_rd;
    logic [AW-1:0]       w_rd_addr;
    logic [AW-1:0]       w_wr_addr;
    logic                w_cnt_we;
    logic                w_tgt_we;
    logic [VAL_W-1:0]    w_cnt_wd;
    logic [VAL_W-1:0]    w_tgt_wd;

    logic                w_out_free;
    logic                w_idx_ok;
    logic                w_full;
    logic                w_last;
    logic [AW-1:0]       w_addr;
    logic [VAL_W-1:0]    w_cnt_inc;
    logic                w_fire;
    logic [XW-1:0]       w_ptr_x;

    assign w_out_free = !r_out_valid || i_ready;
    assign w_idx_ok   = ({{CW{1'b0}}, r_item.idx} < {{IDX_W{1'b0}}, r_created});
    assign w_full     = (r_created == CW'(NUM_TIMERS));
    assign w_last     = ((CW'(r_ptr) + CW'(1)) == r_created);
    assign w_addr     = AW'(r_item.idx);
    assign w_cnt_inc  = r_cnt_rd + VAL_W'(1);
    assign w_fire     = (w_cnt_inc >= r_tgt_rd);
    assign w_ptr_x    = XW'(r_ptr);

    always_comb begin
        n_state     = r_state;
        n_created   = r_created;
        n_ptr       = r_ptr;
        n_item      = r_item;
        n_running   = r_running;
        n_oneshot   = r_oneshot;
        n_res_fired = r_res_fired;
        n_res_slot  = r_res_slot;
        n_res_run   = r_res_run;
        n_res_tgt   = r_res_tgt;
        n_res_err   = r_res_err;
        n_out_valid = r_out_valid;
        n_out_fired = r_out_fired;
        n_out_slot  = r_out_slot;
        n_out_run   = r_out_run;
        n_out_tgt   = r_out_tgt;
        n_out_err   = r_out_err;
        o_q_pop     = 1'b0;
        w_rd_addr   = '0;
        w_wr_addr   = w_addr;
        w_cnt_we    = 1'b0;
        w_tgt_we    = 1'b0;
        w_cnt_wd    = '0;
        w_tgt_wd    = r_item.value;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                o_q_pop = 1'b1;
                w_rd_addr = (i_q_item.kind == KIND_TICK) ? '0 : AW'(i_q_item.idx);
                if (i_q_valid) begin
                    n_item      = i_q_item;
                    n_res_fired = '0;
                    n_res_slot  = '0;
                    n_res_run   = 1'b0;
                    n_res_tgt   = '0;
                    n_res_err   = 1'b0;
                    n_ptr       = '0;
                    if (i_q_item.kind != KIND_TICK) begin
                        n_state = S_EXEC;
                    end else if (r_created == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SWEEP;
                    end
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                if (r_item.kind == KIND_CREATE) begin
                    if (w_full) begin
                        n_res_err = 1'b1;
                    end else begin
                        w_wr_addr = AW'(r_created);
                        w_cnt_we  = 1'b1;
                        w_tgt_we  = 1'b1;
                        n_running[AW'(r_created)] = 1'b0;
                        n_oneshot[AW'(r_created)] = r_item.one_shot;
                        n_created  = CW'(r_created + 1'b1);
                        n_res_slot = IDX_W'(r_created);
                    end
                end else if (!w_idx_ok) begin
                    n_res_err = 1'b1;
                end else begin
                    case (r_item.cmd)
                        CMD_START: n_running[w_addr] = 1'b1;
                        CMD_STOP:  n_running[w_addr] = 1'b0;
                        CMD_RESET: w_cnt_we = 1'b1;
                        CMD_RESTART: begin
                            w_cnt_we = 1'b1;
                            n_running[w_addr] = 1'b1;
                        end
                        CMD_SET: begin
                            n_res_tgt = r_tgt_rd;
                            w_tgt_we  = 1'b1;
                        end
                        CMD_QUERY: begin
                            n_res_run = r_running[w_addr];
                            n_res_tgt = r_tgt_rd;
                        end
                        default: n_res_err = r_res_err;
                    endcase
                end
            end
            S_SWEEP: begin
                // one timer per cycle, next read issued alongside the write-back
                w_rd_addr = AW'(r_ptr + AW'(1));
                w_wr_addr = r_ptr;
                if (r_running[r_ptr]) begin
                    w_cnt_we = 1'b1;
                    w_cnt_wd = w_fire ? '0 : w_cnt_inc;
                    if (w_fire) begin
                        if (r_oneshot[r_ptr]) begin
                            n_running[r_ptr] = 1'b0;
                        end
                        if ({1'b0, w_ptr_x} < (XW + 1)'(MASK_W)) begin
                            n_res_fired[w_ptr_x[2:0]] = 1'b1;
                        end
                    end
                end
                if (w_last) begin
                    n_state = S_DONE;
                end else begin
                    n_ptr = AW'(r_ptr + AW'(1));
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_fired = r_res_fired;
                    n_out_slot  = r_res_slot;
                    n_out_run   = r_res_run;
                    n_out_tgt   = r_res_tgt;
                    n_out_err   = r_res_err;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_created   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_created   <= n_created;
            r_out_valid <= n_out_valid;
        end
        r_ptr       <= n_ptr;
        r_item      <= n_item;
        r_running   <= n_running;
        r_oneshot   <= n_oneshot;
        r_res_fired <= n_res_fired;
        r_res_slot  <= n_res_slot;
        r_res_run   <= n_res_run;
        r_res_tgt   <= n_res_tgt;
        r_res_err   <= n_res_err;
        r_out_fired <= n_out_fired;
        r_out_slot  <= n_out_slot;
        r_out_run   <= n_out_run;
        r_out_tgt   <= n_out_tgt;
        r_out_err   <= n_out_err;
    end

    always_ff @(posedge i_clk) begin
        if (w_cnt_we) begin
            r_cnt_mem[w_wr_addr] <= w_cnt_wd;
        end
        if (w_tgt_we) begin
            r_tgt_mem[w_wr_addr] <= w_tgt_wd;
        end
        r_cnt_rd <= r_cnt_mem[w_rd_addr];
        r_tgt_rd <= r_tgt_mem[w_rd_addr];
    end

    assign o_valid      = r_out_valid;
    assign o_fired_mask = r_out_fired;
    assign o_slot       = r_out_slot;
    assign o_running    = r_out_run;
    assign o_target_out = r_out_tgt;
    assign o_error      = r_out_err;

    a_created_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_created == $past(r_created)) || (r_created == CW'($past(r_created) + 1'b1)))
        else $error("created count jumped");

    a_created_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_created <= CW'(NUM_TIMERS))
        else $error("created count beyond bank size");

    a_sweep_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> (CW'(r_ptr) < r_created))
        else $error("sweep pointer past last created timer");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result word loaded outside completion");

endmodule

// ===== rtl/periodic_oneshot_timer_bank.sv =====
// top level of the periodic / one-shot timer bank
// instantiates ptb_front (accept, classify, queue) and ptb_back (execute)
//
// usage:
//   input channel  i_valid / o_ready carries one command word: i_command,
//   i_timer_index, i_value, i_one_shot. output channel o_valid / i_ready
//   returns exactly one result word per command: o_fired_mask, o_slot,
//   o_running, o_target_out, o_error.
// command flow:
//   a command other than tick passes from accept through queue pop with
//   memory read, execute and result load to o_valid.
//   a tick sweeps the created timers one per cycle through the counter/target
//   memory read port. the back end works on one command at a time.
// reset:
//   synchronous active-low i_rst_n empties the queue, drops o_valid and sets
//   the created count to zero; no timer exists until a create command.
// stall:
//   while i_ready is low the result word holds; the back end finishes its
//   current command and waits, and the two-entry queue keeps accepting
//   command words until it fills, then o_ready drops.
module periodic_oneshot_timer_bank
    import ptb_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_command,
    input  logic [IDX_W-1:0]   i_timer_index,
    input  logic [VAL_W-1:0]   i_value,
    input  logic               i_one_shot,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [MASK_W-1:0]  o_fired_mask,
    output logic [IDX_W-1:0]   o_slot,
    output logic               o_running,
    output logic [VAL_W-1:0]   o_target_out,
    output logic               o_error
);

    // queue handoff between front and back
    logic   w_q_valid;
    t_item  w_q_item;
    logic   w_q_pop;

    ptb_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_command     (i_command),
        .i_timer_index (i_timer_index),
        .i_value       (i_value),
        .i_one_shot    (i_one_shot),
        .o_q_valid     (w_q_valid),
        .o_q_item      (w_q_item),
        .i_q_pop       (w_q_pop)
    );

    // back end owns timer state and the result word register
    ptb_back #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .i_q_item     (w_q_item),
        .o_q_pop      (w_q_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_fired_mask (o_fired_mask),
        .o_slot       (o_slot),
        .o_running    (o_running),
        .o_target_out (o_target_out),
        .o_error      (o_error)
    );

endmodule
